FILE: hdl/motor_speed_pid_step_defines.svh
// assertion macros shared by the motor speed pid step checker
// no dependencies; included by files that carry concurrent assertions
`ifndef MOTOR_SPEED_PID_STEP_DEFINES_SVH
`define MOTOR_SPEED_PID_STEP_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MSPID_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mspid assertion failed");

// next-cycle implication, disabled while reset is low
`define MSPID_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mspid assertion failed");

`endif

FILE: hdl/mspid_pkg.sv
// shared types, constants and helpers of the motor speed pid step
// no dependencies; used by every module of the block
package mspid_pkg;

    // setpoint window and scaling constants
    localparam logic [9:0]  SP_LOW      = 10'd460;
    localparam logic [9:0]  SP_HIGH     = 10'd614;
    localparam logic [10:0] PWM_FULL    = 11'd1023;
    localparam logic [6:0]  PERCENT     = 7'd100;
    localparam logic [7:0]  TERM_LIMIT  = 8'd70;
    localparam logic [7:0]  RPM_OFFSET  = 8'd3;
    // floor(x/10) = (x*205) >> 11 for x below 1024
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    // floor(y/100) is (y*5243) >> 19 or one more, for y below 2^19
    localparam logic [12:0] RECIP_100   = 13'd5243;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_TERM_SELECT = 3'd3,
        REG_SETPOINT    = 3'd4,
        REG_DRIVE_EN    = 3'd5,
        REG_RUN_MODE    = 3'd6
    } reg_idx_t;

    // result status codes
    localparam logic [1:0] STAT_SKIP  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_DRIVE = 2'd2;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_TARGET,
        OP_ERROR,
        OP_TERM_P,
        OP_TERM_I,
        OP_TERM_D,
        OP_MAP,
        OP_RECIP,
        OP_FIX,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic [6:0] gain_p;
        logic [6:0] gain_i;
        logic [6:0] gain_d;
        logic [2:0] term_select;
        logic [9:0] speed_setpoint;
        logic       drive_enable;
        logic       run_mode;
    } cfg_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
    } dp_status_t;

    // result word, lowest field in the lowest bits
    typedef struct packed {
        logic [2:0] pad;
        logic [7:0] speed_error;
        logic [7:0] target_rpm;
        logic       drive_on;
        logic [9:0] drive_value;
        logic [1:0] status;
    } result_t;

    // a term survives only when enabled and within 1..69
    function automatic logic [7:0] keep_term(input logic on, input logic [7:0] raw);
        logic [7:0] t;
        t = raw;
        if (!on || t == 8'd0 || t >= TERM_LIMIT) begin
            t = 8'd0;
        end
        return t;
    endfunction

endpackage

FILE: hdl/mspid_regs.sv
// configuration register file of the motor speed pid step
// depends on mspid_pkg
module mspid_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [9:0]          cfg_wr_data,
    output mspid_pkg::cfg_t     cfg
);

    mspid_pkg::cfg_t cfg_reg;

    // register writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p         <= 7'd0;
            cfg_reg.gain_i         <= 7'd0;
            cfg_reg.gain_d         <= 7'd0;
            cfg_reg.term_select    <= 3'd0;
            cfg_reg.speed_setpoint <= 10'd1;
            cfg_reg.drive_enable   <= 1'b1;
            cfg_reg.run_mode       <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mspid_pkg::REG_GAIN_P:      cfg_reg.gain_p <= cfg_wr_data[6:0];
                mspid_pkg::REG_GAIN_I:      cfg_reg.gain_i <= cfg_wr_data[6:0];
                mspid_pkg::REG_GAIN_D:      cfg_reg.gain_d <= cfg_wr_data[6:0];
                mspid_pkg::REG_TERM_SELECT: cfg_reg.term_select <= cfg_wr_data[2:0];
                mspid_pkg::REG_SETPOINT:    cfg_reg.speed_setpoint <= cfg_wr_data;
                mspid_pkg::REG_DRIVE_EN:    cfg_reg.drive_enable <= cfg_wr_data[0];
                mspid_pkg::REG_RUN_MODE:    cfg_reg.run_mode <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/mspid_datapath.sv
// datapath of the motor speed pid step: target, error, terms, pwm mapping
// depends on mspid_pkg; driven by mspid_ctrl through dp_cmd_t
module mspid_datapath (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mspid_pkg::cfg_t         cfg,
    input  mspid_pkg::dp_cmd_t      cmd,
    input  logic [7:0]              in_rpm,
    output mspid_pkg::dp_status_t   status,
    output mspid_pkg::result_t      result
);

    // loop state
    logic [7:0]  last_error_reg;
    logic [7:0]  error_sum_reg;

    // per-step working registers
    logic        skip_reg;
    logic [7:0]  meas_reg;
    logic [16:0] scaled_reg;
    logic [3:0]  gi10_reg;
    logic [7:0]  target_reg;
    logic [7:0]  err_reg;
    logic [7:0]  d_reg;
    logic [7:0]  acc_reg;
    logic [18:0] y_reg;
    logic [12:0] q0_reg;
    logic [9:0]  drive_reg;
    logic [1:0]  stat_reg;
    mspid_pkg::result_t result_reg;

    logic        skip_now;
    logic [16:0] scaled_calc;
    logic [14:0] gi_prod;
    logic [6:0]  q_hi;
    logic [10:0] rem_sum;
    logic [7:0]  target_calc;
    logic [7:0]  err_calc;
    logic [15:0] tdiv_prod;
    logic [4:0]  tdiv10;
    logic        sum_keep;
    logic [6:0]  mul_a;
    logic [7:0]  mul_b;
    logic        mul_on;
    logic [14:0] mul_prod;
    logic [7:0]  term;
    logic [8:0]  rpm_off;
    logic [18:0] y_calc;
    logic [31:0] recip_prod;
    logic [19:0] chk_prod;
    logic [12:0] drive_full;
    logic        in_range;

    // step runs only in run mode with the setpoint inside its window
    assign skip_now = !cfg.run_mode
                   || (cfg.speed_setpoint < mspid_pkg::SP_LOW)
                   || (cfg.speed_setpoint > mspid_pkg::SP_HIGH);
    assign status.skip = skip_now;

    // setpoint times 100 and integral gain over ten
    assign scaled_calc = 17'(cfg.speed_setpoint) * 17'(mspid_pkg::PERCENT);
    assign gi_prod     = 15'(cfg.gain_i) * 15'(mspid_pkg::DIV10_MUL);

    // divide by 1023: x>>10 is exact or one short
    assign q_hi        = scaled_reg[16:10];
    assign rem_sum     = 11'(scaled_reg[9:0]) + 11'(q_hi);
    assign target_calc = 8'(q_hi) + 8'(rem_sum >= mspid_pkg::PWM_FULL) - mspid_pkg::RPM_OFFSET;

    // error and integral reset test
    assign err_calc  = target_reg - meas_reg;
    assign tdiv_prod = 16'(target_reg) * 16'(mspid_pkg::DIV10_MUL);
    assign tdiv10    = tdiv_prod[15:11];
    assign sum_keep  = err_calc[7] || (err_calc < 8'(tdiv10));

    // shared term multiplier
    always_comb begin
        mul_a  = 7'd0;
        mul_b  = 8'd0;
        mul_on = 1'b0;
        case (cmd.op)
            mspid_pkg::OP_TERM_P: begin
                mul_a  = cfg.gain_p;
                mul_b  = err_reg;
                mul_on = cfg.term_select[2];
            end
            mspid_pkg::OP_TERM_I: begin
                mul_a  = 7'(gi10_reg);
                mul_b  = error_sum_reg;
                mul_on = cfg.term_select[1];
            end
            mspid_pkg::OP_TERM_D: begin
                mul_a  = cfg.gain_d;
                mul_b  = d_reg;
                mul_on = cfg.term_select[0];
            end
            default: begin
            end
        endcase
    end

    assign mul_prod = 15'(mul_a) * 15'(mul_b);
    assign term     = mspid_pkg::keep_term(mul_on, mul_prod[7:0]);

    // map rpm back to pwm: (rpm+3)*1023, then divide by 100
    assign rpm_off    = 9'(acc_reg) + 9'(mspid_pkg::RPM_OFFSET);
    assign y_calc     = {rpm_off, 10'd0} - 19'(rpm_off);
    assign recip_prod = 32'(y_reg) * 32'(mspid_pkg::RECIP_100);
    assign chk_prod   = 20'(q0_reg) * 20'(mspid_pkg::PERCENT);
    assign drive_full = (chk_prod > 20'(y_reg)) ? (q0_reg - 13'd1) : q0_reg;
    assign in_range   = (drive_full >= 13'(mspid_pkg::SP_LOW))
                     && (drive_full <= 13'(mspid_pkg::SP_HIGH));

    // loop state, touched only on a step that runs; the skip flag is captured on every load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg <= 8'd0;
            error_sum_reg  <= 8'd0;
            skip_reg       <= 1'b0;
        end else begin
            if (cmd.op == mspid_pkg::OP_LOAD) begin
                skip_reg <= skip_now;
            end
            if (cmd.op == mspid_pkg::OP_ERROR) begin
                last_error_reg <= err_calc;
                error_sum_reg  <= sum_keep ? (error_sum_reg + err_calc) : 8'd0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            mspid_pkg::OP_LOAD: begin
                meas_reg   <= in_rpm;
                scaled_reg <= scaled_calc;
                gi10_reg   <= gi_prod[14:11];
            end
            mspid_pkg::OP_TARGET: begin
                target_reg <= target_calc;
            end
            mspid_pkg::OP_ERROR: begin
                err_reg <= err_calc;
                d_reg   <= err_calc - last_error_reg;
                acc_reg <= target_reg;
            end
            mspid_pkg::OP_TERM_P, mspid_pkg::OP_TERM_I, mspid_pkg::OP_TERM_D: begin
                acc_reg <= acc_reg + term;
            end
            mspid_pkg::OP_MAP: begin
                y_reg <= y_calc;
            end
            mspid_pkg::OP_RECIP: begin
                q0_reg <= recip_prod[31:19];
            end
            mspid_pkg::OP_FIX: begin
                stat_reg  <= in_range ? mspid_pkg::STAT_DRIVE : mspid_pkg::STAT_RANGE;
                drive_reg <= in_range ? drive_full[9:0] : 10'd0;
            end
            mspid_pkg::OP_EMIT: begin
                result_reg.pad <= 3'd0;
                if (skip_reg) begin
                    result_reg.status      <= mspid_pkg::STAT_SKIP;
                    result_reg.drive_value <= 10'd0;
                    result_reg.drive_on    <= 1'b0;
                    result_reg.target_rpm  <= 8'd0;
                    result_reg.speed_error <= 8'd0;
                end else begin
                    result_reg.status      <= stat_reg;
                    result_reg.drive_value <= drive_reg;
                    result_reg.drive_on    <= (stat_reg == mspid_pkg::STAT_DRIVE)
                                              && cfg.drive_enable;
                    result_reg.target_rpm  <= target_reg;
                    result_reg.speed_error <= err_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign result = result_reg;

endmodule

FILE: hdl/mspid_ctrl.sv
// controller of the motor speed pid step: sequences the datapath and the handshakes
// depends on mspid_pkg; drives mspid_datapath through dp_cmd_t
module mspid_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  mspid_pkg::dp_status_t   status,
    output mspid_pkg::dp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TARGET,
        ST_ERROR,
        ST_TERM_P,
        ST_TERM_I,
        ST_TERM_D,
        ST_MAP,
        ST_RECIP,
        ST_FIX,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   accept;
    logic   slot_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;

    // operation and next state
    always_comb begin
        cmd.op     = mspid_pkg::OP_IDLE;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op     = mspid_pkg::OP_LOAD;
                    state_next = status.skip ? ST_DONE : ST_TARGET;
                end
            end
            ST_TARGET: begin
                cmd.op     = mspid_pkg::OP_TARGET;
                state_next = ST_ERROR;
            end
            ST_ERROR: begin
                cmd.op     = mspid_pkg::OP_ERROR;
                state_next = ST_TERM_P;
            end
            ST_TERM_P: begin
                cmd.op     = mspid_pkg::OP_TERM_P;
                state_next = ST_TERM_I;
            end
            ST_TERM_I: begin
                cmd.op     = mspid_pkg::OP_TERM_I;
                state_next = ST_TERM_D;
            end
            ST_TERM_D: begin
                cmd.op     = mspid_pkg::OP_TERM_D;
                state_next = ST_MAP;
            end
            ST_MAP: begin
                cmd.op     = mspid_pkg::OP_MAP;
                state_next = ST_RECIP;
            end
            ST_RECIP: begin
                cmd.op     = mspid_pkg::OP_RECIP;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.op     = mspid_pkg::OP_FIX;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // wait until the output register is free
                if (slot_free) begin
                    cmd.op     = mspid_pkg::OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid: set on emit, cleared once the transfer completes
    always_comb begin
        if (cmd.op == mspid_pkg::OP_EMIT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: hdl/motor_speed_pid_step.sv
// motor_speed_pid_step: discrete pid speed loop, one step per rpm sample
// Input stream s_*: tdata[7:0] is the measured rpm. Output stream m_*: one
// result transfer per input transfer, in order. Registers are written through
// cfg_wr_en / cfg_addr / cfg_wr_data (index 0..6, higher indexes ignored) and
// should be changed only while no sample is in flight.
// A step that runs walks the controller through target, error, P, I, D
// (on the shared term multiplier), map, the divide-by-100 reciprocal, fix
// and emit before its result shows. A skipped step (run mode off or setpoint
// outside 460..614) goes from the transfer straight to the done state and
// emits from there. A new sample is taken only once the current step has
// emitted; s_tready is high only while the controller is idle.
// The result sits in an output register, so the next sample is taken while a
// result still waits; if m_tready stays low the block finishes that next step
// and then holds in its done state until the register frees.
// Reset (aresetn low, synchronous) clears the loop history, restores the
// register defaults and drops m_tvalid.
// depends on mspid_pkg, mspid_regs, mspid_datapath, mspid_ctrl
module motor_speed_pid_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] measured_rpm
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [1:0] status, [11:2] drive_value, [12] drive_on,
                                   // [20:13] target_rpm, [28:21] speed_error, [31:29] zero
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [9:0]  cfg_wr_data
);

    mspid_pkg::cfg_t        cfg;
    mspid_pkg::dp_cmd_t     cmd;
    mspid_pkg::dp_status_t  status;
    mspid_pkg::result_t     result;

    mspid_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    mspid_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .cmd     (cmd),
        .in_rpm  (s_tdata),
        .status  (status),
        .result  (result)
    );

    mspid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    assign m_tdata = result;

endmodule

FILE: hdl/mspid_checker.sv
// port-level checks of the motor speed pid step, bound to the top level
// depends on mspid_pkg and motor_speed_pid_step_defines.svh
`include "motor_speed_pid_step_defines.svh"

module mspid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic [1:0] out_stat;
    logic [9:0] out_drive;
    logic       stalled;
    logic       no_drive;
    logic       is_skip;
    logic       is_drive;
    logic       in_window;

    // result word fields and status decodes
    assign out_stat  = m_tdata[1:0];
    assign out_drive = m_tdata[11:2];
    assign stalled   = m_tvalid && !m_tready;
    assign no_drive  = m_tvalid && (out_stat != mspid_pkg::STAT_DRIVE);
    assign is_skip   = m_tvalid && (out_stat == mspid_pkg::STAT_SKIP);
    assign is_drive  = m_tvalid && (out_stat == mspid_pkg::STAT_DRIVE);
    assign in_window = (out_drive >= mspid_pkg::SP_LOW) && (out_drive <= mspid_pkg::SP_HIGH);

    // a stalled result stays put
    `MSPID_ASSERT_NXT(a_out_hold, aclk, aresetn, stalled, m_tvalid && $stable(m_tdata))

    // without a drive status there is no drive value and no enable
    `MSPID_ASSERT_IMP(a_no_drive, aclk, aresetn, no_drive, m_tdata[12:2] == 11'd0)

    // a skipped step reports nothing but its status
    `MSPID_ASSERT_IMP(a_skip_zero, aclk, aresetn, is_skip, m_tdata[31:2] == 30'd0)

    // a written drive value lies in the setpoint window
    `MSPID_ASSERT_IMP(a_drive_window, aclk, aresetn, is_drive, in_window)

endmodule

bind motor_speed_pid_step mspid_checker u_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
);

FILE: bench/motor_speed_pid_step_test.sv
`timescale 1ns / 1ps
// self-checking bench for motor_speed_pid_step: rpm sample streams under many
// register settings, every result word checked against a behavioral pid model
// depends on mspid_pkg and the motor_speed_pid_step rtl
module motor_speed_pid_step_test;

    localparam int CLK_HALF = 5;
    localparam int RESET_CYCLES = 12;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TARGET_ITEMS = 1150;
    localparam int IDLE_PCT = 21;

    // pid step predictor and queue of pending result words
    class pid_scoreboard;
        logic [6:0] gain_p, gain_i, gain_d;
        logic [2:0] term_sel;
        logic [9:0] setpoint;
        logic       drive_en, run_mode;
        logic [7:0] last_error, error_sum;
        mspid_pkg::result_t expected_q[$];
        int         errors;

        function new();
            gain_p = '0;
            gain_i = '0;
            gain_d = '0;
            term_sel = '0;
            setpoint = 10'd1;
            drive_en = 1'b1;
            run_mode = 1'b0;
            last_error = '0;
            error_sum = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [9:0] val);
            case (idx)
                mspid_pkg::REG_GAIN_P:      gain_p = val[6:0];
                mspid_pkg::REG_GAIN_I:      gain_i = val[6:0];
                mspid_pkg::REG_GAIN_D:      gain_d = val[6:0];
                mspid_pkg::REG_TERM_SELECT: term_sel = val[2:0];
                mspid_pkg::REG_SETPOINT:    setpoint = val;
                mspid_pkg::REG_DRIVE_EN:    drive_en = val[0];
                mspid_pkg::REG_RUN_MODE:    run_mode = val[0];
                default: ;
            endcase
        endfunction

        // a term counts only when selected and within 1..69
        static function logic [7:0] gate_term(logic on, logic [7:0] raw);
            return (on && raw != 8'd0 && raw < mspid_pkg::TERM_LIMIT) ? raw : 8'd0;
        endfunction

        function void note_sample(logic [7:0] rpm);
            mspid_pkg::result_t r;
            logic [7:0]  target, err, delta, p_term, i_term, d_term, out_rpm;
            int          duty, drive;
            r = '0;
            r.status = mspid_pkg::STAT_SKIP;
            if (run_mode && setpoint >= mspid_pkg::SP_LOW
                    && setpoint <= mspid_pkg::SP_HIGH) begin
                duty = (int'(setpoint) * int'(mspid_pkg::PERCENT))
                       / int'(mspid_pkg::PWM_FULL);
                target = 8'(duty - int'(mspid_pkg::RPM_OFFSET));
                err = target - rpm;
                delta = err - last_error;
                last_error = err;
                // integral accumulates below a tenth of the target, else clears
                if (int'($signed(err)) < int'(target / 8'd10)) begin
                    error_sum = error_sum + err;
                end else begin
                    error_sum = '0;
                end
                p_term = gate_term(term_sel[2], 8'(int'(gain_p) * int'(err)));
                i_term = gate_term(term_sel[1], 8'((int'(gain_i) / 10) * int'(error_sum)));
                d_term = gate_term(term_sel[0], 8'(int'(gain_d) * int'(delta)));
                out_rpm = target + p_term + i_term + d_term;
                drive = ((int'(out_rpm) + int'(mspid_pkg::RPM_OFFSET))
                         * int'(mspid_pkg::PWM_FULL)) / int'(mspid_pkg::PERCENT);
                r.target_rpm = target;
                r.speed_error = err;
                if (drive < int'(mspid_pkg::SP_LOW) || drive > int'(mspid_pkg::SP_HIGH)) begin
                    r.status = mspid_pkg::STAT_RANGE;
                end else begin
                    r.status = mspid_pkg::STAT_DRIVE;
                    r.drive_value = 10'(drive);
                    r.drive_on = drive_en;
                end
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] word);
            mspid_pkg::result_t got, want;
            got = word;
            if (expected_q.size() == 0) begin
                $display("%0t: result 0x%08h with nothing pending: expected none, actual 0x%08h",
                         $time, word, word);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("status", int'(want.status), int'(got.status));
            compare_field("drive_value", int'(want.drive_value), int'(got.drive_value));
            compare_field("drive_on", int'(want.drive_on), int'(got.drive_on));
            compare_field("target_rpm", int'(want.target_rpm), int'(got.target_rpm));
            compare_field("speed_error", int'(want.speed_error), int'(got.speed_error));
            compare_field("pad", 0, int'(got.pad));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [9:0]  cfg_wr_data;

    logic          no_gaps;
    logic          hold_req;
    int            quiet_cycles = 0;
    int            items_sent;
    pid_scoreboard sb;

    motor_speed_pid_step i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // result side ready: random idling, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= no_gaps || (int'($urandom_range(99)) >= IDLE_PCT);
        end
    end

    // result check and watchdog on transfer activity
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // offer one rpm sample, with a random gap ahead of it
    task automatic send_sample(input logic [7:0] rpm);
        int gap;
        gap = 0;
        while (!no_gaps && int'($urandom_range(99)) < IDLE_PCT) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= rpm;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.note_sample(rpm);
        items_sent++;
    endtask

    // samples mostly near the target band, some anywhere in range
    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 60) begin
                send_sample(8'($urandom_range(80, 20)));
            end else begin
                send_sample(8'($urandom_range(255, 0)));
            end
        end
    endtask

    // stop offering and wait until every pending result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [9:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    // rewrite every register, plus a write to the unused index
    task automatic apply_settings(input logic [9:0] gp, input logic [9:0] gi,
                                  input logic [9:0] gd, input logic [9:0] sel,
                                  input logic [9:0] sp, input logic [9:0] den,
                                  input logic [9:0] run);
        put_reg(mspid_pkg::REG_GAIN_P, gp);
        put_reg(mspid_pkg::REG_GAIN_I, gi);
        put_reg(mspid_pkg::REG_GAIN_D, gd);
        put_reg(mspid_pkg::REG_TERM_SELECT, sel);
        put_reg(mspid_pkg::REG_SETPOINT, sp);
        put_reg(mspid_pkg::REG_DRIVE_EN, den);
        put_reg(mspid_pkg::REG_RUN_MODE, run);
        put_reg(REG_UNUSED, 10'($urandom_range(1023, 0)));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [9:0] pick_gain();
        case ($urandom_range(9, 0))
            0: return 10'd0;
            1: return 10'd99;
            2: return 10'd127;
            3: return 10'($urandom_range(1023, 0));
            default: return 10'($urandom_range(99, 0));
        endcase
    endfunction

    // random settings, mostly running with the setpoint inside its window
    task automatic random_phase();
        logic [9:0] sp, run;
        sp = ($urandom_range(99) < 85) ? 10'($urandom_range(614, 460))
                                       : 10'($urandom_range(1023, 0));
        run = ($urandom_range(99) < 92) ? 10'd1 : 10'd0;
        apply_settings(pick_gain(), pick_gain(), pick_gain(), 10'($urandom_range(7, 0)), sp,
                       10'($urandom_range(1, 0)), run);
        send_random(int'($urandom_range(80, 30)));
    endtask

    // main sequence
    initial begin
        int phase;
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: run mode off, every step skipped
        send_sample(8'd0);
        send_sample(8'd255);
        wait_drained();

        // gains of 99, all terms, lowest setpoint
        apply_settings(10'd99, 10'd99, 10'd99, 10'd7, 10'd460, 10'd1, 10'd1);
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd128);
        send_sample(8'd127);
        send_sample(8'd41);
        send_sample(8'd1);
        send_sample(8'd254);
        send_sample(8'd41);
        wait_drained();

        // oversized gains, no terms: output maps below the window
        apply_settings(10'h3ff, 10'd127, 10'd127, 10'd0, 10'd460, 10'd1, 10'd1);
        send_sample(8'd41);
        send_sample(8'd200);
        send_sample(8'd3);
        wait_drained();

        // top setpoint with the drive enable cleared
        apply_settings(10'd5, 10'd55, 10'd7, 10'd7, 10'd614, 10'd0, 10'd1);
        send_sample(8'd57);
        send_sample(8'd50);
        send_sample(8'd60);
        send_sample(8'd30);
        wait_drained();

        // setpoint just outside the window on each side, then run mode off
        apply_settings(10'd20, 10'd30, 10'd40, 10'd7, 10'd459, 10'd1, 10'd1);
        send_sample(8'd10);
        send_sample(8'd90);
        wait_drained();
        apply_settings(10'd20, 10'd30, 10'd40, 10'd7, 10'd615, 10'd1, 10'd1);
        send_sample(8'd10);
        send_sample(8'd90);
        wait_drained();
        apply_settings(10'd20, 10'd30, 10'd40, 10'd7, 10'd500, 10'd1, 10'd0);
        send_sample(8'd10);
        send_sample(8'd90);
        wait_drained();

        // random phases; one runs gap-free, another also stalls the result side
        phase = 0;
        while (items_sent < TARGET_ITEMS) begin
            phase++;
            no_gaps <= (phase == 3 || phase == 6);
            hold_req <= (phase == 6);
            random_phase();
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/mspid_pkg.sv
hdl/mspid_regs.sv
hdl/mspid_datapath.sv
hdl/mspid_ctrl.sv
hdl/motor_speed_pid_step.sv
hdl/mspid_checker.sv
bench/motor_speed_pid_step_test.sv
